FILE: hdl/murmur64b_hash_assert.svh
// Assertion helpers for the hash block. They expect clk and arst_n in scope.
`ifndef MURMUR64B_HASH_ASSERT_SVH
`define MURMUR64B_HASH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/mmh_pkg.sv
package mmh_pkg;

	localparam logic [31:0] MIX_MUL = 32'h5bd1e995;

	localparam int ADDR_W = 4;
	// Register index taken from bit 3 of the byte address.
	localparam logic REG_HASH_SEED = 1'b0;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_NOP  = 4'd0;
	localparam step_t STEP_FULL = 4'd1;
	localparam step_t STEP_PART = 4'd4;
	localparam step_t STEP_FIN  = 4'd5;

	// Multiplier operand selection.
	typedef enum logic [2:0] {
		SRC_WORD,
		SRC_KMIX,
		SRC_LANE,
		SRC_PART,
		SRC_FIN1,
		SRC_FIN2,
		SRC_FIN3,
		SRC_FIN4
	} src_t;

	// Where the product goes.
	typedef enum logic [2:0] {
		DST_NONE,
		DST_K,
		DST_LANE_XK,
		DST_L1,
		DST_L2
	} dst_t;

	// Sequencing of the step counter.
	typedef enum logic [1:0] {
		JC_NEXT,
		JC_END,
		JC_IF_LAST,
		JC_EMIT
	} jc_t;

	typedef struct packed {
		src_t  src;
		dst_t  dst;
		jc_t   jc;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic en;
		src_t src;
		dst_t dst;
	} ctrl_t;

	typedef struct packed {
		logic busy;
		logic emit;
		logic last;
	} seq_stat_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t uw;
		unique case (step)
			4'd0:    uw = '{SRC_WORD, DST_NONE,    JC_END,     STEP_NOP};
			4'd1:    uw = '{SRC_WORD, DST_K,       JC_NEXT,    STEP_NOP};
			4'd2:    uw = '{SRC_KMIX, DST_K,       JC_NEXT,    STEP_NOP};
			4'd3:    uw = '{SRC_LANE, DST_LANE_XK, JC_IF_LAST, STEP_FIN};
			4'd4:    uw = '{SRC_PART, DST_L2,      JC_IF_LAST, STEP_FIN};
			4'd5:    uw = '{SRC_FIN1, DST_L1,      JC_NEXT,    STEP_NOP};
			4'd6:    uw = '{SRC_FIN2, DST_L2,      JC_NEXT,    STEP_NOP};
			4'd7:    uw = '{SRC_FIN3, DST_L1,      JC_NEXT,    STEP_NOP};
			4'd8:    uw = '{SRC_FIN4, DST_L2,      JC_EMIT,    STEP_NOP};
			default: uw = '{SRC_WORD, DST_NONE,    JC_END,     STEP_NOP};
		endcase
		return uw;
	endfunction

endpackage

FILE: hdl/mmh_in_if.sv
interface mmh_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        first_item;
	logic        last_item;
	logic [31:0] message_length;

	modport source (
		output valid, data_word, byte_count, first_item, last_item, message_length,
		input  ready
	);
	modport sink (
		input  valid, data_word, byte_count, first_item, last_item, message_length,
		output ready
	);
endinterface

FILE: hdl/mmh_out_if.sv
interface mmh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (
		output valid, hash_value,
		input  ready
	);
	modport sink (
		input  valid, hash_value,
		output ready
	);
endinterface

FILE: hdl/murmur64b_hash.sv
// MurmurHash64B engine for messages streamed as little-endian 32-bit words.
// The msg channel carries one word per beat with its valid byte count, first
// and last marks and, on the first beat, the message length. The digest channel
// returns one 64-bit hash per message, lane one in the upper half.
// The seed is written over the APB port at byte address 0; write it only while
// no message is in flight.
// Each beat is taken and then run through a short microprogram on one shared
// 32x32 multiplier: a full word gets a word multiply, a mix multiply and a lane
// multiply, a partial word one multiply into lane two and a beat with no bytes
// none. A last beat adds four finalising multiplies before the hash is shown.
// msg.ready is low while the microprogram runs, so no new beat is taken until
// the previous one is through.
// If the receiver stalls, the finished hash waits in the output register; a
// new message may be taken meanwhile, and its result step holds until the
// register frees up.
// Reset clears the seed, both lanes, the word parity and the output valid flag.
`include "murmur64b_hash_assert.svh"

module murmur64b_hash (
	input  logic                        clk,
	input  logic                        arst_n,
	mmh_in_if.sink                      msg,
	mmh_out_if.source                   digest,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mmh_pkg::ADDR_W-1:0]  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);

	logic                 [63:0] seed_q;
	logic                        out_valid_q;
	logic                 [63:0] hash_q;
	logic                        start;
	logic                        out_free;
	logic                 [63:0] hash;
	mmh_pkg::ctrl_t              ctrl;
	mmh_pkg::seq_stat_t          seq_stat;

	assign pready = 1'b1;
	assign prdata = (paddr[mmh_pkg::ADDR_W-1] == mmh_pkg::REG_HASH_SEED) ? seed_q : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (psel && penable && pwrite
				&& (paddr[mmh_pkg::ADDR_W-1] == mmh_pkg::REG_HASH_SEED)) begin
			seed_q <= pwdata;
		end
	end

	assign msg.ready = !seq_stat.busy;
	assign start     = msg.valid && !seq_stat.busy;
	assign out_free  = !out_valid_q || digest.ready;

	mmh_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.start_count (msg.byte_count),
		.start_last  (msg.last_item),
		.out_free    (out_free),
		.ctrl        (ctrl),
		.stat        (seq_stat)
	);

	mmh_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (start),
		.data_word      (msg.data_word),
		.byte_count     (msg.byte_count),
		.first_item     (msg.first_item),
		.message_length (msg.message_length),
		.seed           (seed_q),
		.ctrl           (ctrl),
		.hash           (hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_stat.emit) begin
			out_valid_q <= 1'b1;
		end else if (digest.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_stat.emit) begin
			hash_q <= hash;
		end
	end

	assign digest.valid      = out_valid_q;
	assign digest.hash_value = hash_q;

	`MMH_ASSERT_NEXT(a_busy_after_accept, msg.valid && msg.ready, seq_stat.busy, "beat accepted but sequencer idle")
	`MMH_ASSERT_SAME(a_emit_only_on_last, seq_stat.emit, seq_stat.last, "hash produced for a beat not marked last")
	`MMH_ASSERT_NEXT(a_result_after_emit, seq_stat.emit, digest.valid, "finished hash not presented")

endmodule

FILE: hdl/mmh_seq.sv
module mmh_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        start_count,
	input  logic              start_last,
	input  logic              out_free,
	output mmh_pkg::ctrl_t    ctrl,
	output mmh_pkg::seq_stat_t stat
);

	logic            busy_q;
	logic            last_q;
	mmh_pkg::step_t  step_q;
	mmh_pkg::ucode_t uw;
	mmh_pkg::step_t  entry;
	logic            advance;

	assign uw = mmh_pkg::ucode_rom(step_q);

	// The result step waits until the output register can take the hash.
	assign advance = busy_q && ((uw.jc != mmh_pkg::JC_EMIT) || out_free);

	assign ctrl.en  = advance;
	assign ctrl.src = uw.src;
	assign ctrl.dst = uw.dst;

	assign stat.busy = busy_q;
	assign stat.emit = advance && (uw.jc == mmh_pkg::JC_EMIT);
	assign stat.last = last_q;

	always_comb begin
		if (start_count[2]) begin
			entry = mmh_pkg::STEP_FULL;
		end else if (start_count != 3'd0) begin
			entry = mmh_pkg::STEP_PART;
		end else if (start_last) begin
			entry = mmh_pkg::STEP_FIN;
		end else begin
			entry = mmh_pkg::STEP_NOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			last_q <= 1'b0;
			step_q <= mmh_pkg::STEP_NOP;
		end else if (start) begin
			busy_q <= 1'b1;
			last_q <= start_last;
			step_q <= entry;
		end else if (advance) begin
			unique case (uw.jc)
				mmh_pkg::JC_NEXT: begin
					step_q <= mmh_pkg::step_t'(step_q + 1'b1);
				end
				mmh_pkg::JC_IF_LAST: begin
					if (last_q) begin
						step_q <= uw.target;
					end else begin
						busy_q <= 1'b0;
					end
				end
				mmh_pkg::JC_END, mmh_pkg::JC_EMIT: begin
					busy_q <= 1'b0;
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

FILE: hdl/mmh_dp.sv
module mmh_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic [31:0]    data_word,
	input  logic [2:0]     byte_count,
	input  logic           first_item,
	input  logic [31:0]    message_length,
	input  logic [63:0]    seed,
	input  mmh_pkg::ctrl_t ctrl,
	output logic [63:0]    hash
);

	logic [31:0] lane1_q;
	logic [31:0] lane2_q;
	logic        odd_q;
	logic [31:0] k_q;
	logic [31:0] word_q;
	logic [2:0]  count_q;
	logic [31:0] tail_mask;
	logic [31:0] opa;
	logic [31:0] prod;

	always_comb begin
		case (count_q)
			3'd1:    tail_mask = 32'h0000_00ff;
			3'd2:    tail_mask = 32'h0000_ffff;
			default: tail_mask = 32'h00ff_ffff;
		endcase
	end

	always_comb begin
		case (ctrl.src)
			mmh_pkg::SRC_WORD: opa = word_q;
			mmh_pkg::SRC_KMIX: opa = k_q ^ (k_q >> 24);
			mmh_pkg::SRC_LANE: opa = odd_q ? lane2_q : lane1_q;
			mmh_pkg::SRC_PART: opa = lane2_q ^ (word_q & tail_mask);
			mmh_pkg::SRC_FIN1: opa = lane1_q ^ (lane2_q >> 18);
			mmh_pkg::SRC_FIN2: opa = lane2_q ^ (lane1_q >> 22);
			mmh_pkg::SRC_FIN3: opa = lane1_q ^ (lane2_q >> 17);
			mmh_pkg::SRC_FIN4: opa = lane2_q ^ (lane1_q >> 19);
			default:           opa = word_q;
		endcase
	end

	// The single shared multiplier; only the low half of the product is kept.
	assign prod = opa * mmh_pkg::MIX_MUL;

	// On the result step lane one is already final and the product is lane two.
	assign hash = {lane1_q, prod};

	always_ff @(posedge clk) begin
		if (load) begin
			word_q  <= data_word;
			count_q <= byte_count;
		end
		if (ctrl.en && (ctrl.dst == mmh_pkg::DST_K)) begin
			k_q <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane1_q <= '0;
			lane2_q <= '0;
			odd_q   <= 1'b0;
		end else if (load) begin
			if (first_item) begin
				lane1_q <= seed[31:0] ^ message_length;
				lane2_q <= seed[63:32];
				odd_q   <= 1'b0;
			end
		end else if (ctrl.en) begin
			case (ctrl.dst)
				mmh_pkg::DST_LANE_XK: begin
					if (odd_q) begin
						lane2_q <= prod ^ k_q;
					end else begin
						lane1_q <= prod ^ k_q;
					end
					odd_q <= ~odd_q;
				end
				mmh_pkg::DST_L1: lane1_q <= prod;
				mmh_pkg::DST_L2: lane2_q <= prod;
				default: ;
			endcase
		end
	end

endmodule

FILE: test/hash_checker.sv
module hash_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	mmh_in_if                          msg,
	mmh_out_if                         digest,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [mmh_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                pwdata,
	output int                         fail_count,
	output int                         hashes_pending
);

	logic [63:0] seed_reg;
	logic [31:0] lane_a;
	logic [31:0] lane_b;
	logic        odd_lane;
	logic [63:0] hash_q[$];
	logic [63:0] want;
	logic [63:0] fresh;
	int          reported;

	function automatic logic [31:0] kmix(input logic [31:0] k);
		logic [31:0] t;
		t = k * mmh_pkg::MIX_MUL;
		t = t ^ (t >> 24);
		return t * mmh_pkg::MIX_MUL;
	endfunction

	// Folds one beat into the lanes; returns 1 with the hash when the beat closes a message.
	function automatic bit absorb_beat(input logic [31:0] w, input logic [2:0] n,
			input logic f, input logic l, input logic [31:0] len, output logic [63:0] h);
		logic [31:0] mask;
		h = '0;
		if (f) begin
			lane_a   = seed_reg[31:0] ^ len;
			lane_b   = seed_reg[63:32];
			odd_lane = 1'b0;
		end
		if (n >= 3'd4) begin
			if (odd_lane)
				lane_b = lane_b * mmh_pkg::MIX_MUL ^ kmix(w);
			else
				lane_a = lane_a * mmh_pkg::MIX_MUL ^ kmix(w);
			odd_lane = ~odd_lane;
		end else if (n != 3'd0) begin
			mask   = (n == 3'd1) ? 32'h0000_00ff : (n == 3'd2) ? 32'h0000_ffff : 32'h00ff_ffff;
			lane_b = (lane_b ^ (w & mask)) * mmh_pkg::MIX_MUL;
		end
		if (!l)
			return 1'b0;
		lane_a = (lane_a ^ (lane_b >> 18)) * mmh_pkg::MIX_MUL;
		lane_b = (lane_b ^ (lane_a >> 22)) * mmh_pkg::MIX_MUL;
		lane_a = (lane_a ^ (lane_b >> 17)) * mmh_pkg::MIX_MUL;
		lane_b = (lane_b ^ (lane_a >> 19)) * mmh_pkg::MIX_MUL;
		h = {lane_a, lane_b};
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		fail_count++;
		if (reported < 10) begin
			reported++;
			$display("%s: expected %h, got %h", what, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_reg       = '0;
			lane_a         = '0;
			lane_b         = '0;
			odd_lane       = 1'b0;
			hash_q.delete();
			hashes_pending = 0;
		end else begin
			if (digest.valid && digest.ready) begin
				if (hash_q.size() == 0) begin
					flag_mismatch("hash with none outstanding", 'x, digest.hash_value);
				end else begin
					want = hash_q.pop_front();
					if (want !== digest.hash_value)
						flag_mismatch("hash mismatch", want, digest.hash_value);
				end
			end
			if (psel && penable && pwrite && pready
					&& paddr[3] == mmh_pkg::REG_HASH_SEED)
				seed_reg = pwdata;
			if (msg.valid && msg.ready) begin
				if (absorb_beat(msg.data_word, msg.byte_count, msg.first_item,
						msg.last_item, msg.message_length, fresh))
					hash_q.push_back(fresh);
			end
			hashes_pending = hash_q.size();
		end
	end

	initial begin
		fail_count     = 0;
		reported       = 0;
		hashes_pending = 0;
	end

endmodule

FILE: test/tb.sv
module tb;

	localparam logic [mmh_pkg::ADDR_W-1:0] SEED_ADDR = {mmh_pkg::REG_HASH_SEED, 3'b000};
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_BEATS = 190;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [mmh_pkg::ADDR_W-1:0] paddr;
	logic [63:0]                pwdata;
	logic [63:0]                prdata;
	logic                       pready;
	int                         fail_count;
	int                         hashes_pending;
	int                         beats_sent;
	int                         idle_cycles;
	int                         stall_left;
	bit                         calm;

	mmh_in_if  msg_if ();
	mmh_out_if dig_if ();

	murmur64b_hash u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg     (msg_if),
		.digest  (dig_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	hash_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg            (msg_if),
		.digest         (dig_if),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.fail_count     (fail_count),
		.hashes_pending (hashes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The hash receiver stalls in bursts, except in the closing phase.
	initial begin
		dig_if.ready = 1'b0;
		stall_left   = 0;
		forever begin
			@(negedge clk);
			if (calm) begin
				dig_if.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				dig_if.ready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				dig_if.ready <= 1'b0;
			end else begin
				dig_if.ready <= 1'b1;
			end
		end
	end

	initial idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready) ||
					(psel && penable && pready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic apb_write(input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SEED_ADDR;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_beat(input logic [31:0] w, input logic [2:0] n, input logic f,
			input logic l, input logic [31:0] len);
		if (!calm && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 10)) begin
				@(negedge clk);
				msg_if.valid <= 1'b0;
			end
		end
		@(negedge clk);
		msg_if.valid          <= 1'b1;
		msg_if.data_word      <= w;
		msg_if.byte_count     <= n;
		msg_if.first_item     <= f;
		msg_if.last_item      <= l;
		msg_if.message_length <= len;
		do @(posedge clk); while (!msg_if.ready);
		beats_sent++;
	endtask

	// Drops valid and lets the block drain before the seed may change or the run ends.
	task automatic settle();
		@(negedge clk);
		msg_if.valid <= 1'b0;
		while (hashes_pending != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// Full words, a partial last word where nbytes is not a multiple of four, or one empty beat if nbytes is 0.
	task automatic send_message(input int nbytes, input bit with_first, input bit with_last,
			input logic [31:0] len);
		int       nbeats;
		logic [2:0] n;
		nbeats = (nbytes == 0) ? 1 : (nbytes + 3) / 4;
		for (int i = 0; i < nbeats; i++) begin
			if (nbytes == 0)
				n = 3'd0;
			else if (i == nbeats - 1 && nbytes % 4 != 0)
				n = 3'(nbytes % 4);
			else
				n = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
			send_beat($urandom, n, with_first && i == 0, with_last && i == nbeats - 1,
				(i == 0) ? len : $urandom);
		end
	endtask

	task automatic random_message();
		int          kind;
		int          nbytes;
		logic [31:0] len;
		kind   = $urandom_range(0, 99);
		nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 40);
		len    = ($urandom_range(0, 9) == 0) ? $urandom : nbytes;
		if (kind < 72) begin
			send_message(nbytes, 1'b1, 1'b1, len);
		end else if (kind < 80) begin
			send_message(nbytes, 1'b0, 1'b1, len);
		end else if (kind < 88) begin
			// A partial word in mid-message, then more words without a new start.
			send_message(nbytes & ~3, 1'b1, 1'b0, len);
			send_beat($urandom, 3'($urandom_range(1, 3)), 1'b0, 1'b0, $urandom);
			send_message($urandom_range(0, 16), 1'b0, 1'b1, $urandom);
		end else if (kind < 93) begin
			send_message(nbytes, 1'b1, 1'b0, len);
		end else begin
			repeat ($urandom_range(1, 4))
				send_beat($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom);
		end
	endtask

	initial begin
		logic [63:0] seed;
		int          phase_start;
		arst_n                = 1'b0;
		calm                  = 1'b0;
		beats_sent            = 0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		msg_if.valid          = 1'b0;
		msg_if.data_word      = '0;
		msg_if.byte_count     = '0;
		msg_if.first_item     = 1'b0;
		msg_if.last_item      = 1'b0;
		msg_if.message_length = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Straight after reset, a word with no start mark runs on from the cleared lanes.
		send_beat(32'hffff_ffff, 3'd4, 1'b0, 1'b0, 32'h0);
		send_beat(32'h0000_0000, 3'd0, 1'b0, 1'b1, 32'hffff_ffff);
		send_beat(32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0);
		send_beat(32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'hffff_ffff);
		send_beat(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 32'd1);
		send_beat(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 32'd2);
		send_beat(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 32'd3);
		send_beat(32'ha5a5_5a5a, 3'd7, 1'b1, 1'b1, 32'd4);
		send_beat(32'h5a5a_a5a5, 3'd5, 1'b1, 1'b1, 32'd4);
		send_beat(32'h1234_5678, 3'd2, 1'b1, 1'b0, 32'd6);
		send_beat(32'hffff_ffff, 3'd4, 1'b0, 1'b1, 32'h0);
		// A beat after a finished message carries on from the finalised lanes.
		send_beat(32'hdead_beef, 3'd4, 1'b0, 1'b1, 32'h0);
		send_beat(32'h0123_4567, 3'd4, 1'b1, 1'b0, 32'd12);
		send_beat(32'h89ab_cdef, 3'd6, 1'b0, 1'b0, 32'h0);
		send_beat(32'hffff_ffff, 3'd4, 1'b0, 1'b1, 32'h0);
		send_beat(32'h8000_0001, 3'd4, 1'b1, 1'b0, 32'd5);
		send_beat(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'h0);
		send_beat(32'h7fff_fffe, 3'd1, 1'b0, 1'b1, 32'h0);

		for (int phase = 0; phase < 6; phase++) begin
			settle();
			case (phase)
				0:       seed = 64'hffff_ffff_ffff_ffff;
				1:       seed = 64'hffff_ffff_0000_0000;
				4:       seed = 64'h0000_0000_ffff_ffff;
				5:       seed = 64'h0;
				default: seed = {$urandom, $urandom};
			endcase
			apb_write(seed);
			calm        = (phase == 5);
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS)
				random_message();
		end

		settle();
		if (fail_count == 0 && hashes_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: murmur64b_hash.f
+incdir+hdl
hdl/mmh_pkg.sv
hdl/mmh_in_if.sv
hdl/mmh_out_if.sv
hdl/mmh_seq.sv
hdl/mmh_dp.sv
hdl/murmur64b_hash.sv
test/hash_checker.sv
test/tb.sv
